@@ sv/swm_pkg.sv @@
`default_nettype none
package swm_pkg;

	// Sizes of the window and of one sample.
	localparam int WINDOW_MAX = 32;
	localparam int SAMPLE_WIDTH = 16;
	localparam int CFG_WIDTH = 6;

	// Width of a cell index or an age, and of a count that can hold WINDOW_MAX itself.
	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	// Window length after reset, saturated to the chain length.
	localparam int K_RESET = (3 > WINDOW_MAX) ? WINDOW_MAX : 3;

	// Contents of one cell of the sorted chain.
	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] value;
		logic [IDX_W-1:0] age;
	} cell_t;

	// Values broadcast from the top level to every cell.
	typedef struct packed {
		logic upd;
		logic rem;
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic signed [SAMPLE_WIDTH-1:0] rm_value;
		logic [IDX_W-1:0] oldest_age;
	} bcast_t;

	// Per-cell occupancy flags.
	typedef struct packed {
		logic live;
		logic live_after_rm;
	} occ_t;

endpackage
`default_nettype wire

@@ sv/swm_cell.sv @@
`default_nettype none
module swm_cell (
	input  wire logic clk,
	input  wire swm_pkg::bcast_t bc,
	input  wire swm_pkg::occ_t occ,
	input  wire swm_pkg::cell_t right_cur,
	input  wire swm_pkg::cell_t left_b,
	input  wire logic left_le,
	output swm_pkg::cell_t cur,
	output swm_pkg::cell_t b_out,
	output logic le_out,
	output logic [swm_pkg::SAMPLE_WIDTH-1:0] rm_value_out,
	output swm_pkg::cell_t nxt
);

	swm_pkg::cell_t cell_q;
	logic is_oldest;
	logic after;
	logic shift;

	assign cur = cell_q;

	// This cell holds the oldest sample when its age matches the window length less one.
	assign is_oldest = bc.rem && occ.live && (cell_q.age == bc.oldest_age);
	assign rm_value_out = is_oldest ? cell_q.value : '0;

	// Cells sorted after the removed one: larger value, or equal value and newer.
	assign after = occ.live && ((cell_q.value > bc.rm_value) ||
		((cell_q.value == bc.rm_value) && (cell_q.age < bc.oldest_age)));
	assign shift = bc.rem && (is_oldest || after);

	// Contents after the oldest sample has been taken out of the chain.
	assign b_out = shift ? right_cur : cell_q;
	assign le_out = occ.live_after_rm && (b_out.value <= bc.sample);

	// Keep, take the new sample, or take the left neighbor's contents.
	always_comb begin
		if (le_out) begin
			nxt.value = b_out.value;
			nxt.age = b_out.age + 1'b1;
		end else if (left_le) begin
			nxt.value = bc.sample;
			nxt.age = '0;
		end else begin
			nxt.value = left_b.value;
			nxt.age = left_b.age + 1'b1;
		end
	end

	// Cell register, updated on every accepted transaction.
	always_ff @(posedge clk) begin
		if (bc.upd) begin
			cell_q <= nxt;
		end
	end

endmodule
`default_nettype wire

@@ sv/sliding_window_median_unit.sv @@
// Channel  | Direction | Payload
// ---------+-----------+-----------------------------------------------
// s_axis   | in        | tdata[15:0] = sample (signed)
// m_axis   | out       | tdata[15:0] = median (signed)
// cfg      | in        | cfg_wr_data[5:0] = window_length
//
// One sample is accepted per clock; its median, if any, is presented on the
// next cycle from the output register. The sorted cell chain updates in the
// same cycle in which a sample is accepted: removal of the oldest sample and
// insertion of the new one resolve through one neighbor hop per cell.
// Reset empties the window and sets the window length to three; no clearing
// pass is needed. Input is stalled only while a result waits and m_axis_tready is low.
`default_nettype none
module sliding_window_median_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [15:0] m_axis_tdata,        // [15:0] median
	input  wire logic cfg_wr_en,
	input  wire logic [swm_pkg::CFG_WIDTH-1:0] cfg_wr_data
);

	localparam int N = swm_pkg::WINDOW_MAX;
	localparam int CW = swm_pkg::CNT_W;
	localparam int IW = swm_pkg::IDX_W;

	logic [CW-1:0] k_q;
	logic [IW-1:0] mid_q;
	logic [IW-1:0] oldest_q;
	logic [CW-1:0] fill_q;
	logic out_valid_q;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] median_q;

	logic accept;
	logic rem;
	logic [CW-1:0] fill_rm;
	logic [CW-1:0] fill_nxt;
	logic [CW-1:0] k_wr;
	logic [swm_pkg::SAMPLE_WIDTH-1:0] rm_value;

	swm_pkg::bcast_t bc;
	swm_pkg::occ_t occ [N];
	swm_pkg::cell_t cur [N];
	swm_pkg::cell_t b [N];
	swm_pkg::cell_t nxt [N];
	swm_pkg::cell_t right_cur [N];
	swm_pkg::cell_t left_b [N];
	logic le [N];
	logic left_le [N];
	logic [swm_pkg::SAMPLE_WIDTH-1:0] rm_val [N];

	// Handshake: a new sample enters while the output register is free or being drained.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = median_q;

	// Fill bookkeeping: at most one removal per sample, since fill never exceeds k.
	assign rem = (fill_q >= k_q);
	assign fill_rm = fill_q - {{(CW-1){1'b0}}, rem};
	assign fill_nxt = fill_rm + 1'b1;

	// Value of the oldest cell, gathered from the one-hot removal flags.
	always_comb begin
		rm_value = '0;
		for (int i = 0; i < N; i++) begin
			rm_value = rm_value | rm_val[i];
		end
	end

	assign bc.upd = accept;
	assign bc.rem = rem;
	assign bc.sample = s_axis_tdata[swm_pkg::SAMPLE_WIDTH-1:0];
	assign bc.rm_value = rm_value;
	assign bc.oldest_age = oldest_q;

	// The chain of cells, each linked to its left and right neighbors.
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occ[i].live = (fill_q > CW'(i));
		assign occ[i].live_after_rm = (fill_rm > CW'(i));
		if (i == N - 1) begin : g_right_end
			assign right_cur[i] = cur[i];
		end else begin : g_right
			assign right_cur[i] = cur[i+1];
		end
		if (i == 0) begin : g_left_end
			assign left_b[i] = b[i];
			assign left_le[i] = 1'b1;
		end else begin : g_left
			assign left_b[i] = b[i-1];
			assign left_le[i] = le[i-1];
		end
		swm_cell u_cell (
			.clk          (clk),
			.bc           (bc),
			.occ          (occ[i]),
			.right_cur    (right_cur[i]),
			.left_b       (left_b[i]),
			.left_le      (left_le[i]),
			.cur          (cur[i]),
			.b_out        (b[i]),
			.le_out       (le[i]),
			.rm_value_out (rm_val[i]),
			.nxt          (nxt[i])
		);
	end

	// Effective window length of a configuration write: zero acts as one, and
	// lengths beyond the chain saturate.
	always_comb begin
		if (cfg_wr_data == '0) begin
			k_wr = CW'(1);
		end else if (int'(cfg_wr_data) > N) begin
			k_wr = CW'(N);
		end else begin
			k_wr = CW'(cfg_wr_data);
		end
	end

	// Window length, median index and oldest age registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= CW'(swm_pkg::K_RESET);
			mid_q <= IW'((swm_pkg::K_RESET - 1) / 2);
			oldest_q <= IW'(swm_pkg::K_RESET - 1);
		end else if (cfg_wr_en) begin
			k_q <= k_wr;
			mid_q <= IW'((k_wr - 1'b1) >> 1);
			oldest_q <= IW'(k_wr - 1'b1);
		end
	end

	// Fill count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fill_q <= '0;
			end else if (accept) begin
				fill_q <= fill_nxt;
			end
			if (accept) begin
				out_valid_q <= (fill_nxt == k_q);
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Median register, loaded from the updated chain.
	always_ff @(posedge clk) begin
		if (accept) begin
			median_q <= nxt[mid_q].value;
		end
	end

endmodule
`default_nettype wire

@@ tb/tb_sliding_window_median_unit.sv @@
`timescale 1ns / 1ps
module tb_sliding_window_median_unit;

	typedef logic signed [swm_pkg::SAMPLE_WIDTH-1:0] sample_t;

	localparam int CFG_W = swm_pkg::CFG_WIDTH;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 100;
	localparam int PLAN_LEN = 12;
	localparam int MAX_PRINTED = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [15:0] sample
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [15:0] median
	logic cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	// Idle rates in percent, and a long receiver hold-off requested by a test.
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int sink_hold_request = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	int plan_pos = 0;

	// Window lengths visited by the random phases, extremes and saturating values among them.
	int length_plan [PLAN_LEN] = '{1, 32, 63, 0, 2, 5, 17, 40, 3, 31, 8, 6};

	// Own copy of the window register and of the samples in the window, oldest first.
	logic [CFG_W-1:0] window_reg = CFG_W'(swm_pkg::K_RESET);
	sample_t recent_samples[$];
	sample_t expected_medians[$];

	sliding_window_median_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Free-running clock.
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// A zero length acts as one; lengths beyond the chain saturate.
	function automatic int window_size(input logic [CFG_W-1:0] raw);
		if (raw == 0) return 1;
		if (raw > swm_pkg::WINDOW_MAX) return swm_pkg::WINDOW_MAX;
		return int'(raw);
	endfunction

	// Sorts the current window and picks the lower middle value.
	function automatic sample_t window_median(input int k);
		sample_t sorted [swm_pkg::WINDOW_MAX];
		sample_t v;
		int j;
		for (int i = 0; i < k; i++) begin
			v = recent_samples[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		return sorted[(k - 1) / 2];
	endfunction

	// Slides the window by one sample and queues a median once the window is full.
	function automatic void track_sample(input sample_t s);
		int k;
		k = window_size(window_reg);
		recent_samples.push_back(s);
		while (recent_samples.size() > k) recent_samples.delete(0);
		if (recent_samples.size() == k) expected_medians.push_back(window_median(k));
	endfunction

	// Mix of full-range values, a narrow band full of ties, and the extremes.
	function automatic sample_t random_sample();
		int pick;
		pick = $urandom_range(9);
		if (pick < 5) return sample_t'($urandom);
		if (pick < 8) return sample_t'(int'($urandom_range(16)) - 8);
		case ($urandom_range(3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h8001;
			default: return 16'h7FFE;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED) $display("tb: mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Offers one sample, with an optional gap first, and returns at the edge that accepts it.
	task automatic send_sample(input sample_t s);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s;
		do @(posedge clk); while (!s_axis_tready);
		track_sample(s);
	endtask

	// Stops offering, waits for every queued median, then lets the output stage settle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_medians.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the window register while the block is idle; the window restarts empty.
	task automatic write_window(input int value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CFG_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_reg = CFG_W'(value);
		recent_samples.delete();
	endtask

	// Reset length of three with the sample extremes.
	task automatic test_default_window();
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		send_sample(16'h7FFF);
		send_sample(16'hFFFF);
		send_sample(16'h8000);
		send_sample(16'h0001);
	endtask

	// Zero length behaves as one; an even length gives the lower middle value.
	task automatic test_window_extremes();
		write_window(0);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		send_sample(16'h0000);
		write_window(2);
		send_sample(16'sd5);
		send_sample(-16'sd3);
		send_sample(16'sd7);
		send_sample(16'sd7);
	endtask

	// A register write with a partly filled window discards the samples already held.
	task automatic test_restart_on_write();
		write_window(4);
		send_sample(16'h7FFF);
		send_sample(16'h7FFF);
		write_window(3);
		send_sample(-16'sd5);
		send_sample(-16'sd6);
		send_sample(-16'sd7);
	endtask

	// The receiver holds off for a long stretch while samples keep coming.
	task automatic test_output_backpressure();
		write_window(1);
		sink_hold_request = 80;
		repeat (40) send_sample(random_sample());
	endtask

	// Random samples over four window settings at the given idle rates.
	task automatic test_random_stream(input int src_pct, input int sink_pct);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		repeat (4) begin
			write_window(length_plan[plan_pos % PLAN_LEN]);
			plan_pos++;
			repeat (PHASE_ITEMS) send_sample(random_sample());
		end
	endtask

	// Receiver ready, with random stalls and an occasional long hold-off.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_request > 0) begin
				hold_left = sink_hold_request;
				sink_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Compares each median transaction with the oldest expected median.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_medians.size() == 0) begin
				report_mismatch($sformatf("unexpected median %0d", $signed(m_axis_tdata)));
			end else if (m_axis_tdata !== expected_medians[0]) begin
				report_mismatch($sformatf("median got %0d expected %0d",
					$signed(m_axis_tdata), expected_medians[0]));
				expected_medians.delete(0);
			end else begin
				expected_medians.delete(0);
			end
		end
	end

	// Ends the run when no transaction happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Reset once, then the tests in turn, then the verdict.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 11;
		sink_idle_pct = 48;
		test_default_window();
		test_window_extremes();
		test_restart_on_write();
		test_output_backpressure();
		test_random_stream(11, 48);
		test_random_stream(48, 11);
		test_random_stream(0, 0);
		wait_idle();
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_median_unit.sv
tb/tb_sliding_window_median_unit.sv
